/* src/uer_pkg.sv */
`default_nettype none
package uer_pkg;

    localparam int unsigned TRIG_W  = 10;
    localparam int unsigned GAP_W   = 17;
    localparam int unsigned TICK_W  = 17;
    localparam int unsigned ECHO_W  = 16;
    localparam int unsigned SUM_W   = 19;
    localparam int unsigned PING_W  = 3;
    localparam int unsigned DIST_W  = 15;
    localparam int unsigned FRAC_W  = 4;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 17;

    localparam int unsigned US_PER_CM = 58;

    localparam logic [ECHO_W-1:0] ECHO_MAX = {ECHO_W{1'b1}};
    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic [TRIG_W-1:0] TRIG_RESET = 10'd20;
    localparam logic [GAP_W-1:0]  GAP_RESET  = 17'd100000;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP           = 1'd1;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_TRIG = 3'd1,
        PH_WAIT = 3'd2,
        PH_HIGH = 3'd3,
        PH_GAP  = 3'd4
    } t_phase;

    typedef struct packed {
        logic start_req;
        logic echo_level;
    } t_in;

    typedef struct packed {
        logic              trigger_level;
        logic              busy_res;
        logic              done_res;
        logic [DIST_W-1:0] distance_q4;
    } t_out;

    typedef struct packed {
        logic [TRIG_W-1:0] trigger_width_us;
        logic [GAP_W-1:0]  gap_us;
    } t_cfg;

endpackage
`default_nettype wire

/* src/uer_avg_div.sv */
`default_nettype none
module uer_avg_div #(
    parameter int unsigned PING_COUNT = 5
) (
    input  wire logic [uer_pkg::SUM_W-1:0]  i_sum,
    output logic      [uer_pkg::DIST_W-1:0] o_dist
);

    localparam int unsigned XW      = uer_pkg::SUM_W + uer_pkg::FRAC_W;
    localparam int unsigned DIVISOR = uer_pkg::US_PER_CM * PING_COUNT;
    localparam longint unsigned RECIP = ((64'd1 << 32) + DIVISOR - 1) / DIVISOR;
    localparam int unsigned MW      = $clog2(RECIP + 1);
    localparam int unsigned PW      = XW + MW;
    localparam int unsigned QW      = PW - 32;

    logic [XW-1:0] x;
    logic [PW-1:0] prod;
    logic [QW-1:0] q;
    logic [31:0]   q_ext;

    always_comb begin
        x     = {i_sum, {uer_pkg::FRAC_W{1'b0}}};
        prod  = PW'(x) * PW'(RECIP);
        q     = prod[PW-1:32];
        q_ext = 32'(q);
        o_dist = (q_ext > 32'(uer_pkg::DIST_MAX)) ? uer_pkg::DIST_MAX
                                                  : q_ext[uer_pkg::DIST_W-1:0];
    end

endmodule
`default_nettype wire

/* src/uer_seq.sv */
`default_nettype none
module uer_seq #(
    parameter int unsigned PING_COUNT = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire uer_pkg::t_in  i_in,
    input  wire uer_pkg::t_cfg i_cfg,
    output uer_pkg::t_out      o_res
);

    uer_pkg::t_phase r_phase, n_phase;
    logic [uer_pkg::TICK_W-1:0] r_tick, n_tick;
    logic [uer_pkg::ECHO_W-1:0] r_echo_w, n_echo_w;
    logic [uer_pkg::SUM_W-1:0]  r_sum, n_sum;
    logic [uer_pkg::PING_W-1:0] r_ping, n_ping;

    logic [uer_pkg::SUM_W:0]    sum_add;
    logic [uer_pkg::DIST_W-1:0] div_dist;
    logic                       trig;
    logic                       done;
    logic                       finish;

    uer_avg_div #(
        .PING_COUNT(PING_COUNT)
    ) u_div (
        .i_sum  (n_sum),
        .o_dist (div_dist)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= uer_pkg::PH_IDLE;
            r_tick   <= '0;
            r_echo_w <= '0;
            r_sum    <= '0;
            r_ping   <= '0;
        end else if (i_en) begin
            r_phase  <= n_phase;
            r_tick   <= n_tick;
            r_echo_w <= n_echo_w;
            r_sum    <= n_sum;
            r_ping   <= n_ping;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_echo_w = r_echo_w;
        n_sum    = r_sum;
        n_ping   = r_ping;
        sum_add  = '0;
        trig     = 1'b0;
        done     = 1'b0;
        finish   = 1'b0;

        if (r_phase == uer_pkg::PH_IDLE && i_in.start_req) begin
            n_sum    = '0;
            n_ping   = '0;
            n_echo_w = '0;
            n_tick   = '0;
            n_phase  = uer_pkg::PH_TRIG;
        end

        case (n_phase)
            uer_pkg::PH_TRIG: begin
                trig   = 1'b1;
                n_tick = n_tick + uer_pkg::TICK_W'(1);
                if (n_tick >= uer_pkg::TICK_W'(i_cfg.trigger_width_us)) begin
                    n_tick  = '0;
                    n_phase = uer_pkg::PH_WAIT;
                end
            end
            uer_pkg::PH_WAIT: begin
                if (i_in.echo_level) begin
                    n_echo_w = uer_pkg::ECHO_W'(1);
                    n_phase  = uer_pkg::PH_HIGH;
                end
            end
            uer_pkg::PH_HIGH: begin
                if (i_in.echo_level) begin
                    if (n_echo_w != uer_pkg::ECHO_MAX) begin
                        n_echo_w = n_echo_w + uer_pkg::ECHO_W'(1);
                    end
                end else begin
                    sum_add  = {1'b0, n_sum} + (uer_pkg::SUM_W + 1)'(n_echo_w);
                    n_sum    = sum_add[uer_pkg::SUM_W] ? uer_pkg::SUM_MAX
                                                       : sum_add[uer_pkg::SUM_W-1:0];
                    n_echo_w = '0;
                    n_ping   = n_ping + uer_pkg::PING_W'(1);
                    n_tick   = '0;
                    if (i_cfg.gap_us == '0) begin
                        finish = 1'b1;
                    end else begin
                        n_phase = uer_pkg::PH_GAP;
                    end
                end
            end
            uer_pkg::PH_GAP: begin
                n_tick = n_tick + uer_pkg::TICK_W'(1);
                if (n_tick >= uer_pkg::TICK_W'(i_cfg.gap_us)) begin
                    finish = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (finish) begin
            if (n_ping >= uer_pkg::PING_W'(PING_COUNT)) begin
                done    = 1'b1;
                n_phase = uer_pkg::PH_IDLE;
            end else begin
                n_phase = uer_pkg::PH_TRIG;
            end
            n_tick = '0;
        end

        o_res.trigger_level = trig;
        o_res.busy_res      = (n_phase != uer_pkg::PH_IDLE);
        o_res.done_res      = done;
        o_res.distance_q4   = done ? div_dist : '0;
    end

endmodule
`default_nettype wire

/* src/ultrasonic_echo_ranger_unit.sv */
// Latency: a result is valid in the cycle after its tick request is accepted.
// Throughput: one tick request per cycle; the result register is reloaded in
// the same cycle it is taken, so a stalled result blocks only the next request.
// Average division is one rounded-up reciprocal multiply, inside the cycle.
// Reset (synchronous, active low) idles the sequencer, clears its counters and
// sets trigger width to 20 and gap to 100000.
`default_nettype none
module ultrasonic_echo_ranger_unit #(
    parameter int unsigned PING_COUNT = 5
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire uer_pkg::t_in                    i_in,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output uer_pkg::t_out                        o_out,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [uer_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [uer_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    uer_pkg::t_cfg r_cfg;
    uer_pkg::t_out r_out;
    uer_pkg::t_out n_out;
    logic          r_out_valid;
    logic          in_accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_width_us <= uer_pkg::TRIG_RESET;
            r_cfg.gap_us           <= uer_pkg::GAP_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                uer_pkg::CFG_TRIGGER_WIDTH: begin
                    r_cfg.trigger_width_us <= i_cfg_data[uer_pkg::TRIG_W-1:0];
                end
                uer_pkg::CFG_GAP: begin
                    r_cfg.gap_us <= i_cfg_data[uer_pkg::GAP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    uer_seq #(
        .PING_COUNT(PING_COUNT)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (in_accept),
        .i_in    (i_in),
        .i_cfg   (r_cfg),
        .o_res   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.done_res |-> !r_out.busy_res)
        else $error("done result reports busy");

    a_dist_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.done_res |-> r_out.distance_q4 == '0)
        else $error("distance nonzero outside done");

    a_trig_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.trigger_level |-> r_out.busy_res)
        else $error("trigger high while idle");

    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted request produced no result");

endmodule
`default_nettype wire

/* test/ultrasonic_echo_ranger_unit_tb.sv */
`default_nettype none
module ultrasonic_echo_ranger_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import uer_pkg::*;

    localparam int unsigned PINGS = 5;
    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int unsigned SHOWN_MAX = 10;
    localparam int unsigned ITEM_TARGET = 1650;

    typedef enum int {
        START_NONE,
        START_RANDOM,
        START_HELD
    } t_start_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in                   i_in;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out                  o_out;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ultrasonic_echo_ranger_unit #(
        .PING_COUNT(PINGS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in(i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out(o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    t_phase            ph;
    logic [TICK_W-1:0] tick_cnt;
    logic [ECHO_W-1:0] echo_cnt;
    logic [SUM_W-1:0]  width_total;
    logic [PING_W-1:0] pings_done;
    logic [TRIG_W-1:0] trig_us;
    logic [GAP_W-1:0]  gap_len;

    t_out        pending_readings[$];
    t_out        want;
    int unsigned ticks_sent;
    int unsigned results_seen;
    int unsigned fail_count;
    int unsigned shown;
    int unsigned cycles;
    bit          no_stalls;

    int unsigned tw_cur;
    int unsigned gap_cur;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_out range_step(t_in req);
        t_out             r;
        logic             ping_over;
        logic [SUM_W:0]   total;
        logic [31:0]      q;
        r = '0;
        ping_over = 1'b0;
        if (ph == PH_IDLE && req.start_req) begin
            width_total = '0;
            pings_done = '0;
            echo_cnt = '0;
            tick_cnt = '0;
            ph = PH_TRIG;
        end
        case (ph)
            PH_TRIG: begin
                r.trigger_level = 1'b1;
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt >= trig_us) begin
                    tick_cnt = '0;
                    ph = PH_WAIT;
                end
            end
            PH_WAIT: begin
                if (req.echo_level) begin
                    echo_cnt = ECHO_W'(1);
                    ph = PH_HIGH;
                end
            end
            PH_HIGH: begin
                if (req.echo_level) begin
                    if (echo_cnt != ECHO_MAX) echo_cnt = echo_cnt + 1'b1;
                end else begin
                    total = width_total + echo_cnt;
                    width_total = (total > SUM_MAX) ? SUM_MAX : total[SUM_W-1:0];
                    echo_cnt = '0;
                    pings_done = pings_done + 1'b1;
                    tick_cnt = '0;
                    if (gap_len == '0) ping_over = 1'b1;
                    else ph = PH_GAP;
                end
            end
            PH_GAP: begin
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt >= gap_len) ping_over = 1'b1;
            end
            default: ;
        endcase
        if (ping_over) begin
            if (pings_done >= PINGS) begin
                q = (32'(width_total) << FRAC_W) / (US_PER_CM * PINGS);
                if (q > DIST_MAX) q = DIST_MAX;
                r.done_res = 1'b1;
                r.distance_q4 = q[DIST_W-1:0];
                ph = PH_IDLE;
            end else begin
                ph = PH_TRIG;
            end
            tick_cnt = '0;
        end
        r.busy_res = (ph != PH_IDLE);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ph = PH_IDLE;
            tick_cnt = '0;
            echo_cnt = '0;
            width_total = '0;
            pings_done = '0;
            trig_us = TRIG_RESET;
            gap_len = GAP_RESET;
            pending_readings.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_TRIGGER_WIDTH) trig_us = i_cfg_data[TRIG_W-1:0];
                else if (i_cfg_index == CFG_GAP) gap_len = i_cfg_data[GAP_W-1:0];
            end
            if (i_in_valid && o_in_ready) pending_readings.push_back(range_step(i_in));
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (pending_readings.size() == 0) begin
                    fail_count++;
                    if (shown < SHOWN_MAX) begin
                        shown++;
                        $display("unexpected result: trig=%0d busy=%0d done=%0d dist=%0d",
                                 o_out.trigger_level, o_out.busy_res, o_out.done_res,
                                 o_out.distance_q4);
                    end
                end else begin
                    want = pending_readings.pop_front();
                    if (o_out.trigger_level !== want.trigger_level ||
                        o_out.busy_res !== want.busy_res ||
                        o_out.done_res !== want.done_res ||
                        o_out.distance_q4 !== want.distance_q4) begin
                        fail_count++;
                        if (shown < SHOWN_MAX) begin
                            shown++;
                            $display("mismatch at result %0d: expected trig=%0d busy=%0d %s",
                                     results_seen, want.trigger_level, want.busy_res,
                                     $sformatf("done=%0d dist=%0d, got trig=%0d busy=%0d %s",
                                     want.done_res, want.distance_q4, o_out.trigger_level,
                                     o_out.busy_res, $sformatf("done=%0d dist=%0d",
                                     o_out.done_res, o_out.distance_q4)));
                        end
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= no_stalls || ($urandom_range(99) >= 33);
    end

    function automatic int unsigned trig_ticks();
        return (tw_cur == 0) ? 1 : tw_cur;
    endfunction

    function automatic logic start_bit(t_start_mode mode);
        if (mode == START_HELD) return 1'b1;
        if (mode == START_RANDOM) return logic'($urandom_range(1));
        return 1'b0;
    endfunction

    task automatic send_tick(input logic start, input logic echo);
        t_in item;
        item.start_req = start;
        item.echo_level = echo;
        if (!no_stalls && $urandom_range(99) < 33) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 33);
        end
        i_in_valid <= 1'b1;
        i_in <= item;
        do @(posedge i_clk); while (!o_in_ready);
        ticks_sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (results_seen < ticks_sent) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_timing(input logic [TRIG_W-1:0] tw, input logic [GAP_W-1:0] gap);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_TRIGGER_WIDTH;
        i_cfg_data <= {{(CFG_DATA_W-TRIG_W){1'b0}}, tw};
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_GAP;
        i_cfg_data <= gap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tw_cur = tw;
        gap_cur = gap;
    endtask

    task automatic send_ping(input bit first, input int unsigned wait_n,
                             input int unsigned high_n, input t_start_mode mode);
        int unsigned i;
        for (i = 0; i < trig_ticks(); i++)
            send_tick((first && i == 0) ? 1'b1 : start_bit(mode), logic'($urandom_range(1)));
        repeat (wait_n) send_tick(start_bit(mode), 1'b0);
        repeat (high_n) send_tick(start_bit(mode), 1'b1);
        repeat (gap_cur + 1) send_tick(start_bit(mode), 1'b0);
    endtask

    task automatic run_measurement(input t_start_mode mode, input int unsigned max_wait,
                                   input int unsigned max_high);
        send_ping(1'b1, $urandom_range(max_wait), $urandom_range(1, max_high), mode);
        repeat (PINGS - 1)
            send_ping(1'b0, $urandom_range(max_wait), $urandom_range(1, max_high), mode);
    endtask

    // walk the sequencer back to idle from any phase
    task automatic recover();
        repeat (PINGS + 1) begin
            send_tick(1'b0, 1'b1);
            repeat (trig_ticks() + gap_cur + 2) send_tick(1'b0, 1'b0);
        end
    endtask

    // enter a long gap, then shorten it so the gap ends on the next tick
    task automatic ping_then_cut_gap(input logic [GAP_W-1:0] new_gap);
        int unsigned i;
        for (i = 0; i < trig_ticks(); i++) send_tick(i == 0, logic'($urandom_range(1)));
        repeat (3) send_tick(1'b0, 1'b0);
        repeat (5) send_tick(1'b0, 1'b1);
        repeat (11) send_tick(1'b0, 1'b0);
        settle();
        set_timing(tw_cur[TRIG_W-1:0], new_gap);
        send_tick(1'b0, 1'b0);
        repeat (PINGS - 1)
            send_ping(1'b0, $urandom_range(4), $urandom_range(1, 12), START_NONE);
        settle();
    endtask

    // enter a long trigger, then shorten it so the trigger ends on the next tick
    task automatic ping_then_cut_trigger(input logic [TRIG_W-1:0] new_tw);
        int unsigned i;
        for (i = 0; i < 16; i++) send_tick(i == 0, logic'($urandom_range(1)));
        settle();
        set_timing(new_tw, gap_cur[GAP_W-1:0]);
        send_tick(1'b0, 1'b1);
        repeat (2) send_tick(1'b0, 1'b0);
        repeat (4) send_tick(1'b0, 1'b1);
        repeat (gap_cur + 1) send_tick(1'b0, 1'b0);
        repeat (PINGS - 1)
            send_ping(1'b0, $urandom_range(4), $urandom_range(1, 12), START_NONE);
        settle();
    endtask

    task automatic test_power_on_timing();
        ping_then_cut_gap(17'd2);
    endtask

    task automatic test_timing_extremes();
        set_timing(10'd0, 17'd0);
        run_measurement(START_NONE, 3, 8);
        settle();
        set_timing(10'd1023, 17'd1);
        ping_then_cut_trigger(10'd2);
        set_timing(10'd1, 17'd131071);
        ping_then_cut_gap(17'd3);
    endtask

    task automatic test_long_echo();
        set_timing(10'd1, 17'd0);
        no_stalls = 1'b1;
        send_ping(1'b1, 0, 240, START_NONE);
        send_ping(1'b0, 1, 180, START_NONE);
        repeat (PINGS - 2) send_ping(1'b0, 1, 3, START_NONE);
        no_stalls = 1'b0;
        settle();
    endtask

    task automatic test_start_held();
        set_timing(10'd2, 17'd1);
        run_measurement(START_HELD, 3, 6);
        run_measurement(START_RANDOM, 3, 6);
        settle();
    endtask

    task automatic test_random_traffic();
        int unsigned pick;
        logic [TRIG_W-1:0] tw;
        logic [GAP_W-1:0] gap;
        while (ticks_sent < ITEM_TARGET) begin
            pick = $urandom_range(9);
            if (pick <= 6) begin
                settle();
                case ($urandom_range(9))
                    0: tw = '0;
                    1: tw = TRIG_W'($urandom_range(7, 64));
                    default: tw = TRIG_W'($urandom_range(1, 6));
                endcase
                gap = ($urandom_range(4) == 0) ? GAP_W'($urandom_range(6, 40))
                                               : GAP_W'($urandom_range(5));
                set_timing(tw, gap);
                no_stalls = ($urandom_range(7) == 0);
                run_measurement(t_start_mode'($urandom_range(2)), 5, $urandom_range(1, 30));
                no_stalls = 1'b0;
            end else if (pick <= 8) begin
                repeat ($urandom_range(10, 60))
                    send_tick($urandom_range(3) == 0, logic'($urandom_range(1)));
                recover();
            end else begin
                run_measurement(START_RANDOM, 40, 10);
            end
        end
        settle();
    endtask

    initial begin
        ticks_sent = 0;
        results_seen = 0;
        fail_count = 0;
        shown = 0;
        no_stalls = 1'b0;
        tw_cur = TRIG_RESET;
        gap_cur = GAP_RESET;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_TRIGGER_WIDTH;
        i_cfg_data <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_power_on_timing();
        test_timing_extremes();
        test_long_echo();
        test_start_held();
        test_random_traffic();
        settle();
        if (fail_count == 0 && pending_readings.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire

/* filelist.f */
src/uer_pkg.sv
src/uer_avg_div.sv
src/uer_seq.sv
src/ultrasonic_echo_ranger_unit.sv
test/ultrasonic_echo_ranger_unit_tb.sv
